// ===== rtl/vrn_pkg.sv =====
// vrn_pkg: shared widths, types and arithmetic helpers for vector_rotate_normalize
// no dependencies
package vrn_pkg;
  localparam int CompWidth = 16;
  localparam int FracBits  = 14;
  localparam int SqWidth   = 2 * CompWidth + 2;
  localparam int LenWidth  = SqWidth / 2;
  localparam int NumLanes  = 3;
  localparam int QWidth    = CompWidth + FracBits + 2;
  localparam int DivSteps  = QWidth;

  typedef logic signed [CompWidth-1:0] comp_t;
  typedef logic signed [2*CompWidth+3:0] wide_t;

  function automatic comp_t clip(input wide_t v, output logic sat);
    wide_t hi;
    wide_t lo;
    hi = wide_t'((64'sd1 <<< (CompWidth - 1)) - 1);
    lo = -wide_t'(64'sd1 <<< (CompWidth - 1));
    sat = 1'b0;
    if (v > hi) begin
      sat = 1'b1;
      return comp_t'(hi);
    end
    if (v < lo) begin
      sat = 1'b1;
      return comp_t'(lo);
    end
    return comp_t'(v);
  endfunction

  // operands never exceed 18 signed bits (component or one minus cosine)
  function automatic wide_t qmul(input wide_t a, input wide_t b);
    logic signed [CompWidth+1:0] ma;
    logic signed [CompWidth+1:0] mb;
    wide_t pr;
    ma = a[CompWidth+1:0];
    mb = b[CompWidth+1:0];
    pr = ma * mb + (wide_t'(1) <<< (FracBits - 1));
    return pr >>> FracBits;
  endfunction
endpackage

// ===== rtl/vrn_if.sv =====
// vrn_if: valid/ready channel interfaces
// depends on vrn_pkg
interface vrn_in_if import vrn_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t p_x, p_y, p_z, axis_x, axis_y, axis_z, cos_angle, sin_angle;
  modport source (output valid, p_x, p_y, p_z, axis_x, axis_y, axis_z, cos_angle,
    sin_angle, input ready);
  modport sink (input valid, p_x, p_y, p_z, axis_x, axis_y, axis_z, cos_angle,
    sin_angle, output ready);
endinterface

interface vrn_out_if import vrn_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t r_x, r_y, r_z;
  logic  zero_length;
  logic  saturated;
  modport source (output valid, r_x, r_y, r_z, zero_length, saturated, input ready);
  modport sink (input valid, r_x, r_y, r_z, zero_length, saturated, output ready);
endinterface

interface vrn_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/vector_rotate_normalize.sv =====
// Rodrigues rotation with optional normalization, fully pipelined: one request per cycle
// whenever the output is not stalled. The pipe is made of four arithmetic stages,
// LenWidth square root stages, a divider setup stage, DivSteps divider stages and the
// output register. Three divider lanes run side by side and a merge stage combines
// their quotients and saturation flags. Output backpressure freezes the whole pipe.
// depends on vrn_pkg, vrn_if, vrn_sqrt, vrn_div_lane
module vector_rotate_normalize import vrn_pkg::*; (
  input logic clk,
  input logic rst,
  vrn_in_if.sink    in_ch,
  vrn_out_if.source out_ch,
  vrn_cfg_if.sink   cfg
);
  localparam int Lat = 4 + LenWidth + 1 + DivSteps + 1;

  logic normalize;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) normalize <= 1'b1;
    else if (cfg.valid) normalize <= cfg.data;
  end

  // skid-free stall: whole pipe advances when output slot is free
  logic en;
  logic [Lat-1:0] vld;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: p.n terms and cross products
  comp_t p1 [3];
  comp_t n1 [3];
  comp_t c1, s1;
  comp_t pn1;
  comp_t cr1 [3];
  logic  sat1, nrm1;
  always_ff @(posedge clk) begin
    if (en) begin
      logic s0, sa, sb, sc;
      wide_t px, py, pz, nx, ny, nz;
      px = wide_t'(in_ch.p_x); py = wide_t'(in_ch.p_y); pz = wide_t'(in_ch.p_z);
      nx = wide_t'(in_ch.axis_x); ny = wide_t'(in_ch.axis_y); nz = wide_t'(in_ch.axis_z);
      pn1    <= clip(qmul(px, nx) + qmul(py, ny) + qmul(pz, nz), s0);
      cr1[0] <= clip(qmul(ny, pz) - qmul(nz, py), sa);
      cr1[1] <= clip(qmul(nz, px) - qmul(nx, pz), sb);
      cr1[2] <= clip(qmul(nx, py) - qmul(ny, px), sc);
      sat1 <= s0 | sa | sb | sc;
      p1[0] <= in_ch.p_x; p1[1] <= in_ch.p_y; p1[2] <= in_ch.p_z;
      n1[0] <= in_ch.axis_x; n1[1] <= in_ch.axis_y; n1[2] <= in_ch.axis_z;
      c1 <= in_ch.cos_angle; s1 <= in_ch.sin_angle;
      nrm1 <= normalize;
    end
  end

  // stage 2: k
  comp_t p2 [3];
  comp_t n2 [3];
  comp_t cr2 [3];
  comp_t c2, s2, k2;
  logic  sat2, nrm2;
  always_ff @(posedge clk) begin
    if (en) begin
      logic sk;
      k2 <= clip(qmul(wide_t'(pn1), (wide_t'(1) <<< FracBits) - wide_t'(c1)), sk);
      sat2 <= sat1 | sk;
      p2 <= p1; n2 <= n1; cr2 <= cr1; c2 <= c1; s2 <= s1; nrm2 <= nrm1;
    end
  end

  // stage 3: rotated vector
  comp_t r3 [3];
  logic  sat3, nrm3;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [2:0] sr;
      for (int i = 0; i < 3; i++) begin
        r3[i] <= clip(qmul(wide_t'(c2), wide_t'(p2[i])) + qmul(wide_t'(k2), wide_t'(n2[i]))
                      + qmul(wide_t'(s2), wide_t'(cr2[i])), sr[i]);
      end
      sat3 <= sat2 | (|sr);
      nrm3 <= nrm2;
    end
  end

  // stage 4: sum of squares
  logic [SqWidth-1:0] sq4;
  comp_t r4 [3];
  logic  sat4, nrm4;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [2*CompWidth-1:0] m0, m1, m2;
      m0 = r3[0] * r3[0];
      m1 = r3[1] * r3[1];
      m2 = r3[2] * r3[2];
      sq4 <= SqWidth'(m0) + SqWidth'(m1) + SqWidth'(m2);
      r4 <= r3; sat4 <= sat3; nrm4 <= nrm3;
    end
  end

  logic [LenWidth-1:0] len_s;
  vrn_sqrt u_sqrt (.clk(clk), .en(en), .sq(sq4), .len(len_s));

  // delay side data across sqrt
  comp_t rd [LenWidth+1][3];
  logic  sd [LenWidth+1];
  logic  nd [LenWidth+1];
  logic  zd [LenWidth+1];
  assign rd[0] = r4; assign sd[0] = sat4; assign nd[0] = nrm4; assign zd[0] = (sq4 == '0);
  for (genvar j = 0; j < LenWidth; j++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        rd[j+1] <= rd[j]; sd[j+1] <= sd[j]; nd[j+1] <= nd[j]; zd[j+1] <= zd[j];
      end
    end
  end

  // divider setup stage
  logic [QWidth-1:0] num5 [3];
  logic [LenWidth-1:0] den5;
  comp_t r5 [3];
  logic  s5, n5, z5;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [CompWidth-1:0] a;
        a = rd[LenWidth][i][CompWidth-1] ? CompWidth'(-rd[LenWidth][i])
                                          : CompWidth'(rd[LenWidth][i]);
        num5[i] <= (QWidth'(a) << FracBits) + QWidth'(len_s >> 1);
      end
      den5 <= (len_s == '0) ? LenWidth'(1) : len_s;
      r5 <= rd[LenWidth]; s5 <= sd[LenWidth]; n5 <= nd[LenWidth]; z5 <= zd[LenWidth];
    end
  end

  logic [QWidth-1:0] quo [3];
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    vrn_div_lane u_div (.clk(clk), .en(en), .num(num5[l]), .den(den5), .quo(quo[l]));
  end

  comp_t rq [DivSteps+1][3];
  logic  sq_ [DivSteps+1];
  logic  nq [DivSteps+1];
  logic  zq [DivSteps+1];
  assign rq[0] = r5; assign sq_[0] = s5; assign nq[0] = n5; assign zq[0] = z5;
  for (genvar j = 0; j < DivSteps; j++) begin : g_qd
    always_ff @(posedge clk) begin
      if (en) begin
        rq[j+1] <= rq[j]; sq_[j+1] <= sq_[j]; nq[j+1] <= nq[j]; zq[j+1] <= zq[j];
      end
    end
  end

  // merge stage into output register
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_ch.valid};
  end
  assign out_ch.valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (en) begin
      logic [2:0] sn;
      comp_t o [3];
      for (int i = 0; i < 3; i++) begin
        wide_t qv;
        qv = wide_t'({2'b00, quo[i]});
        o[i] = clip(rq[DivSteps][i][CompWidth-1] ? -qv : qv, sn[i]);
      end
      if (nq[DivSteps] && !zq[DivSteps]) begin
        out_ch.r_x <= o[0]; out_ch.r_y <= o[1]; out_ch.r_z <= o[2];
        out_ch.saturated <= sq_[DivSteps] | (|sn);
      end else begin
        out_ch.r_x <= rq[DivSteps][0]; out_ch.r_y <= rq[DivSteps][1];
        out_ch.r_z <= rq[DivSteps][2];
        out_ch.saturated <= sq_[DivSteps];
      end
      out_ch.zero_length <= nq[DivSteps] && zq[DivSteps];
    end
  end

  ap_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.r_x))
    else $error("output changed under stall");
  ap_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready mismatch");
  ap_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.zero_length |-> out_ch.r_x == '0 && out_ch.r_y == '0)
    else $error("zero flag with nonzero vector");
endmodule

// ===== rtl/vrn_div_lane.sv =====
// vrn_div_lane: one pipelined restoring divider lane, one quotient bit per stage
// depends on vrn_pkg
module vrn_div_lane import vrn_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [QWidth-1:0]   num,
  input  logic [LenWidth-1:0] den,
  output logic [QWidth-1:0]   quo
);
  logic [QWidth-1:0]   q   [DivSteps+1];
  logic [LenWidth:0]   rem [DivSteps+1];
  logic [QWidth-1:0]   nm  [DivSteps+1];
  logic [LenWidth-1:0] dd  [DivSteps+1];

  assign q[0]   = '0;
  assign rem[0] = '0;
  assign nm[0]  = num;
  assign dd[0]  = den;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [LenWidth+1:0] sh;
    logic [LenWidth+1:0] df;
    assign sh = {rem[i], nm[i][QWidth-1-i]};
    assign df = sh - {2'b00, dd[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        nm[i+1] <= nm[i];
        dd[i+1] <= dd[i];
        if (!df[LenWidth+1]) begin
          rem[i+1] <= df[LenWidth:0];
          q[i+1]   <= {q[i][QWidth-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh[LenWidth:0];
          q[i+1]   <= {q[i][QWidth-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q[DivSteps];
endmodule

// ===== rtl/vrn_sqrt.sv =====
// vrn_sqrt: pipelined integer square root, rounded to nearest, one result bit per stage
// depends on vrn_pkg
module vrn_sqrt import vrn_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SqWidth-1:0]  sq,
  output logic [LenWidth-1:0] len
);
  logic [SqWidth-1:0]  v   [LenWidth+1];
  logic [LenWidth-1:0] r   [LenWidth+1];

  assign v[0] = sq;
  assign r[0] = '0;

  for (genvar i = 0; i < LenWidth; i++) begin : g_step
    localparam int B = LenWidth - 1 - i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v[i] >= ((SqWidth'(r[i]) << (B + 1) | (SqWidth'(1) << (2 * B))))) begin
          v[i+1] <= v[i] - ((SqWidth'(r[i]) << (B + 1)) | (SqWidth'(1) << (2 * B)));
          r[i+1] <= r[i] | (LenWidth'(1) << B);
        end else begin
          v[i+1] <= v[i];
          r[i+1] <= r[i];
        end
      end
    end
  end

  // remainder above root means round up
  assign len = r[LenWidth] + LenWidth'(v[LenWidth] > SqWidth'(r[LenWidth]));
endmodule
